/* hdl/gill_pkg.sv */
// Package: shared types, codes and helpers for the Gillespie reaction selector.
`timescale 1ns / 1ps
package gill_pkg;

  localparam logic [1:0]  MODE_LOAD_RATE = 2'd0;
  localparam logic [1:0]  MODE_LOAD_POP  = 2'd1;
  localparam logic [1:0]  MODE_DRAW      = 2'd2;
  localparam logic [31:0] LN2_Q32        = 32'd2977044472;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  reaction_index;
    logic [31:0] load_value;
    logic [31:0] uniform_pick;
    logic [31:0] uniform_time;
    logic [63:0] now_time;
  } item_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  chosen_reaction;
    logic [63:0] next_time;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUM_MUL, ST_SUM_ADD, ST_CHECK, ST_TGT_LO, ST_TGT_HI, ST_SEL_MUL,
    ST_SEL_ADD, ST_NORM, ST_SQ_MUL, ST_SQ_STEP, ST_LN_LO, ST_LN_HI, ST_DIV_INIT,
    ST_DIV
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_START, OP_SUM_MUL, OP_SUM_ADD, OP_FIN_ZERO, OP_TGT_LO,
    OP_TGT_HI, OP_SEL_MUL, OP_SEL_ADD, OP_LOG_INIT, OP_NORM, OP_SQ_MUL, OP_SQ_STEP,
    OP_LN_LO, OP_LN_HI, OP_DIV_INIT, OP_DIV, OP_FINISH
  } op_e;

  typedef struct packed {
    logic cnt_eq_n;
    logic cnt_31;
    logic cnt_63;
    logic total_zero;
    logic hit;
    logic x_norm;
  } status_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage

/* hdl/gillespie_reaction_select.sv */
// Top level: Gillespie direct-method reaction selector.
//   channel   signals                    transfer when
//   item      start, busy, item_i        start high and busy low
//   result    done_o, result_o           done_o high (one cycle, no back-pressure)
//   config    cfg_we_i, cfg_wdata_i      cfg_we_i high
// Loads leave busy low. A draw runs the two table passes (n entries in use, the second
// walking m entries up to the chosen one), the normalising shift (s leading zeros of
// uniform_time, 0 to 31), the 32 squaring steps of the log unit and the 64-step
// restoring divider. A zero total ends the draw after the first pass. busy falls as
// done_o rises, so the next item may transfer in the result cycle. Reset clears both
// tables and the count.
`timescale 1ns / 1ps
module gillespie_reaction_select
  import gill_pkg::*;
#(
  parameter int MAX_REACTIONS   = 16,
  parameter int POPULATION_BITS = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  item_t      item_i,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  output logic       done_o,
  output result_t    result_o
);

  op_e     op;
  status_t status;

  gill_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .mode_i   (item_i.mode),
    .status_i (status),
    .op_o     (op),
    .busy     (busy)
  );

  gill_dp #(
    .MAX_REACTIONS   (MAX_REACTIONS),
    .POPULATION_BITS (POPULATION_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .status_o    (status),
    .done_o      (done_o),
    .result_o    (result_o)
  );

endmodule

/* hdl/gill_ctrl.sv */
// Controller: sequencing state machine for loads and draws.
`timescale 1ns / 1ps
module gill_ctrl
  import gill_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  logic [1:0] mode_i,
  input  status_t status_i,
  output op_e     op_o,
  output logic    busy
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (mode_i == MODE_LOAD_RATE || mode_i == MODE_LOAD_POP) begin
            op_o = OP_LOAD;
          end else if (mode_i == MODE_DRAW) begin
            op_o    = OP_START;
            state_d = ST_SUM_MUL;
          end
        end
      end
      ST_SUM_MUL: begin
        if (status_i.cnt_eq_n) begin
          state_d = ST_CHECK;
        end else begin
          op_o    = OP_SUM_MUL;
          state_d = ST_SUM_ADD;
        end
      end
      ST_SUM_ADD: begin
        op_o    = OP_SUM_ADD;
        state_d = ST_SUM_MUL;
      end
      ST_CHECK: begin
        if (status_i.total_zero) begin
          op_o    = OP_FIN_ZERO;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_TGT_LO;
        end
      end
      ST_TGT_LO: begin
        op_o    = OP_TGT_LO;
        state_d = ST_TGT_HI;
      end
      ST_TGT_HI: begin
        op_o    = OP_TGT_HI;
        state_d = ST_SEL_MUL;
      end
      ST_SEL_MUL: begin
        if (status_i.cnt_eq_n || status_i.hit) begin
          op_o    = OP_LOG_INIT;
          state_d = ST_NORM;
        end else begin
          op_o    = OP_SEL_MUL;
          state_d = ST_SEL_ADD;
        end
      end
      ST_SEL_ADD: begin
        op_o    = OP_SEL_ADD;
        state_d = ST_SEL_MUL;
      end
      ST_NORM: begin
        if (status_i.x_norm) begin
          state_d = ST_SQ_MUL;
        end else begin
          op_o = OP_NORM;
        end
      end
      ST_SQ_MUL: begin
        op_o    = OP_SQ_MUL;
        state_d = ST_SQ_STEP;
      end
      ST_SQ_STEP: begin
        op_o    = OP_SQ_STEP;
        state_d = status_i.cnt_31 ? ST_LN_LO : ST_SQ_MUL;
      end
      ST_LN_LO: begin
        op_o    = OP_LN_LO;
        state_d = ST_LN_HI;
      end
      ST_LN_HI: begin
        op_o    = OP_LN_HI;
        state_d = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        op_o    = OP_DIV_INIT;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (status_i.cnt_63) begin
          op_o    = OP_FINISH;
          state_d = ST_IDLE;
        end else begin
          op_o = OP_DIV;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

/* hdl/gill_dp.sv */
// Datapath: tables, sums, selection, log unit and restoring divider.
`timescale 1ns / 1ps
module gill_dp
  import gill_pkg::*;
#(
  parameter int MAX_REACTIONS   = 16,
  parameter int POPULATION_BITS = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  op_e        op_i,
  input  item_t      item_i,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  output status_t    status_o,
  output logic       done_o,
  output result_t    result_o
);

  localparam int DEPTH = (MAX_REACTIONS < 16) ? MAX_REACTIONS : 16;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [31:0]                rate_q [DEPTH];
  logic [POPULATION_BITS-1:0] pop_q  [DEPTH];
  logic [4:0]  cfg_q;
  logic [4:0]  n_lim;
  logic [6:0]  cnt_q;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] wr_idx;
  logic        rd_ok;
  logic [31:0] rate_rd;
  logic [31:0] pop_rd;
  logic [31:0] upick_q, utime_q;
  logic [63:0] now_q;
  logic [63:0] prod_q, total_q, run_q, target_q, sq_q, ln_q, quo_q, rem_q;
  logic [3:0]  chosen_q;
  logic        hit_q;
  logic [31:0] x_q, frac_q;
  logic [4:0]  s_q;
  logic [63:0] run_nx;
  logic [63:0] mul_a;
  logic [32:0] sq_t;
  logic [5:0]  s_inc;
  logic [37:0] nl;
  logic [63:0] ln_lo;
  logic [64:0] rem_sh;
  logic        done_q;
  result_t     res_q;

  assign n_lim  = (cfg_q > 5'(DEPTH)) ? 5'(DEPTH) : cfg_q;
  assign rd_idx = cnt_q[IW-1:0];
  assign wr_idx = item_i.reaction_index[IW-1:0];
  assign rd_ok  = (cnt_q < 7'(DEPTH));
  assign rate_rd = rd_ok ? rate_q[rd_idx] : '0;
  assign pop_rd  = rd_ok ? 32'(pop_q[rd_idx]) : '0;
  assign run_nx  = sat_add(run_q, prod_q);
  assign sq_t    = sq_q[63:31];
  assign s_inc   = {1'b0, s_q} + 6'd1;
  assign nl      = {s_inc, 32'b0} - {6'b0, frac_q};
  assign mul_a   = 64'(total_q[31:0]) * 64'(upick_q);
  assign ln_lo   = 64'(nl[31:0]) * 64'(LN2_Q32);
  assign rem_sh  = {rem_q, quo_q[63]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        rate_q[i] <= '0;
        pop_q[i]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (op_i == OP_LOAD && ({1'b0, item_i.reaction_index} < 5'(DEPTH))) begin
        if (item_i.mode == MODE_LOAD_RATE) begin
          rate_q[wr_idx] <= item_i.load_value;
        end else begin
          pop_q[wr_idx] <= item_i.load_value[POPULATION_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (op_i == OP_FIN_ZERO) || (op_i == OP_FINISH);
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_START: begin
        upick_q  <= item_i.uniform_pick;
        utime_q  <= item_i.uniform_time;
        now_q    <= item_i.now_time;
        total_q  <= '0;
        cnt_q    <= '0;
      end
      OP_SUM_MUL, OP_SEL_MUL: prod_q <= 64'(pop_rd) * 64'(rate_rd);
      OP_SUM_ADD: begin
        total_q <= sat_add(total_q, prod_q);
        cnt_q   <= cnt_q + 7'd1;
      end
      OP_FIN_ZERO: begin
        res_q.found           <= 1'b0;
        res_q.chosen_reaction <= '0;
        res_q.next_time       <= now_q;
      end
      OP_TGT_LO: target_q <= {32'b0, mul_a[63:32]};
      OP_TGT_HI: begin
        target_q <= target_q + 64'(total_q[63:32]) * 64'(upick_q);
        cnt_q    <= '0;
        run_q    <= '0;
        hit_q    <= 1'b0;
        chosen_q <= '0;
      end
      OP_SEL_ADD: begin
        run_q <= run_nx;
        if (run_nx > target_q) begin
          hit_q    <= 1'b1;
          chosen_q <= cnt_q[3:0];
        end
        cnt_q <= cnt_q + 7'd1;
      end
      OP_LOG_INIT: begin
        x_q    <= (utime_q == '0) ? 32'd1 : utime_q;
        s_q    <= '0;
        frac_q <= '0;
        cnt_q  <= '0;
      end
      OP_NORM: begin
        x_q <= {x_q[30:0], 1'b0};
        s_q <= s_q + 5'd1;
      end
      OP_SQ_MUL: sq_q <= 64'(x_q) * 64'(x_q);
      OP_SQ_STEP: begin
        x_q    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
        frac_q <= {frac_q[30:0], sq_t[32]};
        cnt_q  <= cnt_q + 7'd1;
      end
      OP_LN_LO: ln_q <= {32'b0, ln_lo[63:32]};
      OP_LN_HI: ln_q <= ln_q + 64'(nl[37:32]) * 64'(LN2_Q32);
      OP_DIV_INIT: begin
        quo_q <= {ln_q[47:0], 16'b0};
        rem_q <= '0;
        cnt_q <= '0;
      end
      OP_DIV, OP_FINISH: begin
        if (rem_sh >= {1'b0, total_q}) begin
          rem_q <= 64'(rem_sh - {1'b0, total_q});
          quo_q <= {quo_q[62:0], 1'b1};
        end else begin
          rem_q <= rem_sh[63:0];
          quo_q <= {quo_q[62:0], 1'b0};
        end
        cnt_q <= cnt_q + 7'd1;
        if (op_i == OP_FINISH) begin
          res_q.found           <= 1'b1;
          res_q.chosen_reaction <= chosen_q;
          res_q.next_time       <= sat_add(now_q, {quo_q[62:0],
                                   (rem_sh >= {1'b0, total_q})});
        end
      end
      default: ;
    endcase
  end

  assign status_o.cnt_eq_n   = (cnt_q == {2'b0, n_lim});
  assign status_o.cnt_31     = (cnt_q == 7'd31);
  assign status_o.cnt_63     = (cnt_q == 7'd63);
  assign status_o.total_zero = (total_q == '0);
  assign status_o.hit        = hit_q;
  assign status_o.x_norm     = x_q[31];
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

/* hdl/gill_checker.sv */
// Checker: port-level properties of the reaction selector, bound to the top level.
`timescale 1ns / 1ps
module gill_checker
  import gill_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input item_t   item_i,
  input logic    done_o,
  input result_t result_o
);

  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.mode == MODE_DRAW) |=> busy)
    else $error("draw did not raise busy");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.mode != MODE_DRAW) |=> !busy)
    else $error("load or unused mode raised busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.found) |-> (result_o.chosen_reaction == '0))
    else $error("no reaction found but index non-zero");

endmodule

bind gillespie_reaction_select gill_checker u_gill_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .item_i   (item_i),
  .done_o   (done_o),
  .result_o (result_o)
);
